[design/oal_pkg.sv]
// shared types and constants for the ordered array list core
// no dependencies
package oal_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int WORD_W   = 32;

	typedef enum logic [2:0] {
		FN_APPEND  = 3'd0,
		FN_INSERT  = 3'd1,
		FN_REMOVE  = 3'd2,
		FN_WRITE   = 3'd3,
		FN_READ    = 3'd4,
		FN_CLEAR   = 3'd5,
		FN_RESTART = 3'd6,
		FN_NEXT    = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_APPEND,
		ACT_PUT_POS,
		ACT_INS_START,
		ACT_SHIFT_UP,
		ACT_INS_FINAL,
		ACT_RM_LAST,
		ACT_RM_START,
		ACT_SHIFT_DN,
		ACT_SHIFT_DN_END,
		ACT_READ_POS,
		ACT_READ_CUR,
		ACT_CAPTURE,
		ACT_CLEAR,
		ACT_RESTART
	} act_t;

	typedef struct packed {
		logic latch;
		act_t act;
		logic ok_load;
		logic out_load;
	} oal_cmd_t;

	typedef struct packed {
		func_t op;
		logic  op_ok;
		logic  ins_at_end;
		logic  rm_last;
		logic  up_done;
		logic  dn_done;
	} oal_status_t;

endpackage

[design/oal_dpath.sv]
// datapath: entry memory, count, cursor, shift index and result registers
// depends on oal_pkg
module oal_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oal_pkg::oal_cmd_t                   cmd,
	output oal_pkg::oal_status_t                status,
	input  logic [2:0]                          func,
	input  logic [oal_pkg::CNT_W-1:0]           position,
	input  logic signed [oal_pkg::WORD_W-1:0]   value,
	output logic                                ok,
	output logic signed [oal_pkg::WORD_W-1:0]   read_value,
	output logic [oal_pkg::CNT_W-1:0]           length_now,
	output logic                                more_left
);
	import oal_pkg::*;

	logic [WORD_W-1:0] mem [CAPACITY];
	logic [WORD_W-1:0] rdata_q;

	func_t             op_q;
	logic [CNT_W-1:0]  pos_q;
	logic [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cursor_q;
	logic [ADDR_W-1:0] idx_q;
	logic              ok_q;
	logic [WORD_W-1:0] rd_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	logic full;
	logic pos_in_list;
	logic next_ok;

	assign full        = (count_q == CNT_W'(CAPACITY));
	assign pos_in_list = (pos_q < count_q);
	assign next_ok     = (cursor_q < count_q);

	always_comb begin
		status.op         = op_q;
		status.ins_at_end = (pos_q == count_q);
		status.rm_last    = (pos_q == count_q - CNT_W'(1));
		status.up_done    = (CNT_W'(idx_q) == pos_q + CNT_W'(1));
		status.dn_done    = (CNT_W'(idx_q) + CNT_W'(2) == count_q);
		case (op_q)
			FN_APPEND:  status.op_ok = !full;
			FN_INSERT:  status.op_ok = !full && (pos_q <= count_q);
			FN_REMOVE:  status.op_ok = pos_in_list;
			FN_WRITE:   status.op_ok = pos_in_list;
			FN_READ:    status.op_ok = pos_in_list;
			FN_NEXT:    status.op_ok = next_ok;
			default:    status.op_ok = 1'b1;
		endcase
	end

	// memory port selection per action
	always_comb begin
		we    = 1'b0;
		waddr = pos_q[ADDR_W-1:0];
		wdata = val_q;
		re    = 1'b0;
		raddr = pos_q[ADDR_W-1:0];
		case (cmd.act)
			ACT_APPEND: begin
				we    = 1'b1;
				waddr = count_q[ADDR_W-1:0];
			end
			ACT_PUT_POS, ACT_INS_FINAL: begin
				we = 1'b1;
			end
			ACT_INS_START: begin
				re    = 1'b1;
				raddr = count_q[ADDR_W-1:0] - ADDR_W'(1);
			end
			ACT_SHIFT_UP: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
				re    = 1'b1;
				raddr = idx_q - ADDR_W'(2);
			end
			ACT_RM_START: begin
				re    = 1'b1;
				raddr = pos_q[ADDR_W-1:0] + ADDR_W'(1);
			end
			ACT_SHIFT_DN: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
				re    = 1'b1;
				raddr = idx_q + ADDR_W'(2);
			end
			ACT_SHIFT_DN_END: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
			end
			ACT_READ_POS: begin
				re = 1'b1;
			end
			ACT_READ_CUR: begin
				re    = 1'b1;
				raddr = cursor_q[ADDR_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// list count and iteration cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			case (cmd.act)
				ACT_APPEND, ACT_INS_FINAL:     count_q <= count_q + CNT_W'(1);
				ACT_RM_LAST, ACT_SHIFT_DN_END: count_q <= count_q - CNT_W'(1);
				ACT_READ_CUR:                  cursor_q <= cursor_q + CNT_W'(1);
				ACT_RESTART:                   cursor_q <= '0;
				ACT_CLEAR: begin
					count_q  <= '0;
					cursor_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// request word, shift index and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= func_t'(func);
			pos_q <= position;
			val_q <= value;
			rd_q  <= '0;
		end
		case (cmd.act)
			ACT_INS_START: idx_q <= count_q[ADDR_W-1:0];
			ACT_SHIFT_UP:  idx_q <= idx_q - ADDR_W'(1);
			ACT_RM_START:  idx_q <= pos_q[ADDR_W-1:0];
			ACT_SHIFT_DN:  idx_q <= idx_q + ADDR_W'(1);
			ACT_CAPTURE:   rd_q  <= rdata_q;
			default:       idx_q <= idx_q;
		endcase
		if (cmd.ok_load) begin
			ok_q <= status.op_ok;
		end
		if (cmd.out_load) begin
			ok         <= ok_q;
			read_value <= rd_q;
			length_now <= count_q;
			more_left  <= next_ok;
		end
	end

endmodule

[design/oal_ctrl.sv]
// controller: sequences each operation and owns both handshakes
// depends on oal_pkg
module oal_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  oal_pkg::oal_status_t status,
	output oal_pkg::oal_cmd_t    cmd
);
	import oal_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SHIFT_UP,
		ST_INS_FINAL,
		ST_SHIFT_DN,
		ST_RD_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	// a waiting result only holds the sequencer at the output load
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.latch    = 1'b0;
		cmd.act      = ACT_NONE;
		cmd.ok_load  = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.ok_load = 1'b1;
				state_d     = ST_FINISH;
				if (status.op_ok) begin
					case (status.op)
						FN_APPEND: cmd.act = ACT_APPEND;
						FN_INSERT: begin
							if (status.ins_at_end) begin
								cmd.act = ACT_INS_FINAL;
							end else begin
								cmd.act = ACT_INS_START;
								state_d = ST_SHIFT_UP;
							end
						end
						FN_REMOVE: begin
							if (status.rm_last) begin
								cmd.act = ACT_RM_LAST;
							end else begin
								cmd.act = ACT_RM_START;
								state_d = ST_SHIFT_DN;
							end
						end
						FN_WRITE: cmd.act = ACT_PUT_POS;
						FN_READ: begin
							cmd.act = ACT_READ_POS;
							state_d = ST_RD_WAIT;
						end
						FN_CLEAR:   cmd.act = ACT_CLEAR;
						FN_RESTART: cmd.act = ACT_RESTART;
						FN_NEXT: begin
							cmd.act = ACT_READ_CUR;
							state_d = ST_RD_WAIT;
						end
						default: cmd.act = ACT_NONE;
					endcase
				end
			end
			ST_SHIFT_UP: begin
				cmd.act = ACT_SHIFT_UP;
				if (status.up_done) begin
					state_d = ST_INS_FINAL;
				end
			end
			ST_INS_FINAL: begin
				cmd.act = ACT_INS_FINAL;
				state_d = ST_FINISH;
			end
			ST_SHIFT_DN: begin
				if (status.dn_done) begin
					cmd.act = ACT_SHIFT_DN_END;
					state_d = ST_FINISH;
				end else begin
					cmd.act = ACT_SHIFT_DN;
				end
			end
			ST_RD_WAIT: begin
				cmd.act = ACT_CAPTURE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/ordered_array_list_core.sv]
// sequence: an accepted word passes through the evaluate state, then the shift states for an insert
// inside the list or a remove below the top, or the read-wait state for read and next, then the
// finish state, which holds while an earlier result word stays stalled
// the next word is taken while a result waits, not before the last word is loaded as a result
// reset: count and cursor clear at once, no memory sweep, slots at or above the count never read
// depends on oal_pkg, oal_ctrl, oal_dpath
module ordered_array_list_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          func,
	input  logic [oal_pkg::CNT_W-1:0]           position,
	input  logic signed [oal_pkg::WORD_W-1:0]   value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic signed [oal_pkg::WORD_W-1:0]   read_value,
	output logic [oal_pkg::CNT_W-1:0]           length_now,
	output logic                                more_left
);
	import oal_pkg::*;

	// command and status between sequencer and datapath
	oal_cmd_t    cmd;
	oal_status_t status;

	// sequencer: evaluates the latched word, walks the shift, loads the result register
	oal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: entry memory with registered read, count, cursor and result registers
	oal_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.func       (func),
		.position   (position),
		.value      (value),
		.ok         (ok),
		.read_value (read_value),
		.length_now (length_now),
		.more_left  (more_left)
	);

endmodule
